// File: design/twsc_pkg.sv
package twsc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 18;
    localparam int TANH_TABLE_DEPTH_DEF = 256;

    // Magnitudes: Q15 unity and the drive saturation point (8.0)
    localparam int MAG_W = 19;
    localparam logic [MAG_W-1:0] XD_MAX = 19'd262144;
    localparam logic [15:0] Q15_ONE = 16'd32768;

    // Q15 curve constants
    localparam logic [15:0] C_1P3  = 16'd42598;
    localparam logic [15:0] C_0P85 = 16'd27853;
    localparam logic [15:0] C_0P75 = 16'd24576;
    localparam logic [15:0] C_0P35 = 16'd11469;
    localparam logic [15:0] C_0P65 = 16'd21299;

    // Configuration register indexes
    localparam logic [1:0] REG_BYPASS = 2'd0;
    localparam logic [1:0] REG_MODEL  = 2'd1;
    localparam logic [1:0] REG_DRIVE  = 2'd2;
    localparam logic [1:0] REG_BIAS   = 2'd3;

    typedef enum logic [1:0] {
        MODEL_SOFT  = 2'd0,
        MODEL_CLIP  = 2'd1,
        MODEL_ASYM  = 2'd2,
        MODEL_PLAIN = 2'd3
    } t_model;

    // Restoring shift-subtract quotient, used while building the table only
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned dnm);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= dnm) begin
                rem    = rem - dnm;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // One tanh table entry, round(32768*tanh(8*i/depth)), built as (1-E)/(1+E)
    // with E = exp(-16*i/depth) in Q30. Evaluated at elaboration only.
    function automatic logic [15:0] tanh_entry(input int unsigned i, input int unsigned depth);
        longint unsigned one;
        longint unsigned den;
        longint unsigned zq;
        longint unsigned term;
        longint unsigned s;
        longint unsigned e;
        longint unsigned q;
        longint sum;
        one  = 64'd1 << 30;
        den  = 64'(4 * depth);
        zq   = div_u64((64'(i) << 30) + (den >> 1), den);
        sum  = longint'(one);
        term = one;
        for (int k = 1; k <= 10; k++) begin
            term = div_u64((term * zq) >> 30, 64'(k));
            if ((k & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        s = longint'(sum);
        for (int k = 0; k < 6; k++) begin
            s = (s * s + (64'd1 << 29)) >> 30;
        end
        e = (s > one) ? one : s;
        q = div_u64(((one - e) << 15) + ((one + e) >> 1), one + e);
        return q[15:0];
    endfunction

endpackage

// File: design/twsc_tanh.sv
module twsc_tanh #(
    parameter int TANH_TABLE_DEPTH = twsc_pkg::TANH_TABLE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [twsc_pkg::MAG_W-1:0]  i_mag,
    output logic [15:0]                 o_tanh
);
    import twsc_pkg::*;

    localparam int IDX_W = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int P_W   = MAG_W + IDX_W;
    localparam int FR_W  = 18;

    logic [15:0] w_tab [0:TANH_TABLE_DEPTH];

    // Constant table, depth+1 entries
    for (genvar g = 0; g <= TANH_TABLE_DEPTH; g++) begin : g_tab
        localparam logic [15:0] ENTRY = tanh_entry(g, TANH_TABLE_DEPTH);
        assign w_tab[g] = ENTRY;
    end

    logic [P_W-1:0]   w_p;
    logic [IDX_W-1:0] w_idx;
    logic [15:0]      n_lo, n_hi;
    logic [FR_W-1:0]  n_frac;

    logic [15:0]      r_lo_a, r_hi_a, r_lo_b, r_y;
    logic [FR_W-1:0]  r_frac_a;
    logic [33:0]      r_prod_b;

    assign w_p   = P_W'(i_mag) * P_W'(TANH_TABLE_DEPTH);
    assign w_idx = w_p[FR_W +: IDX_W];

    // Split into table index and fraction; saturate at the last entry
    always_comb begin
        if (i_mag >= XD_MAX) begin
            n_lo   = w_tab[TANH_TABLE_DEPTH];
            n_hi   = w_tab[TANH_TABLE_DEPTH];
            n_frac = '0;
        end else begin
            n_lo   = w_tab[w_idx];
            n_hi   = w_tab[w_idx + IDX_W'(1)];
            n_frac = w_p[FR_W-1:0];
            if (n_hi < n_lo) begin
                n_hi = n_lo;
            end
        end
    end

    // Lookup, slope product, rounded interpolation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_a   <= n_lo;
            r_hi_a   <= n_hi;
            r_frac_a <= n_frac;
            r_lo_b   <= r_lo_a;
            r_prod_b <= 34'(r_hi_a - r_lo_a) * 34'(r_frac_a);
            r_y      <= r_lo_b + 16'((r_prod_b + 34'(1 << 17)) >> 18);
        end
    end

    assign o_tanh = r_y;

endmodule

// File: design/tube_waveshaper_curve_core.sv
// Tube waveshaper: each word is scaled by the drive gain, then shaped by one of four tanh
// curves (soft, clip hybrid, asymmetric, plain) from an interpolated constant table, and
// saturated to the sample width; bypass passes the word unchanged. The pipeline is nine
// register stages deep and takes one word per cycle; a stalled output freezes every stage
// without losing words. Write configuration only while no word is in flight.
module tube_waveshaper_curve_core #(
    parameter int SAMPLE_WIDTH     = twsc_pkg::SAMPLE_WIDTH_DEF,
    parameter int TANH_TABLE_DEPTH = twsc_pkg::TANH_TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [15:0]                    i_cfg_data
);
    import twsc_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int PR_W = SW - 1 + 16;
    localparam int YW   = ((SW > MAG_W) ? SW : MAG_W) + 1;
    localparam logic signed [YW-1:0] Y_HI = YW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [YW-1:0] Y_LO = -YW'(64'sd1 <<< (SW - 1));

    // Configuration registers
    logic        r_bypass;
    t_model      r_model;
    logic [15:0] r_drive, r_bias, r_coef;
    logic [15:0] w_bias_c;
    logic [31:0] w_bias_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass <= 1'b0;
            r_model  <= MODEL_SOFT;
            r_drive  <= 16'd1024;
            r_bias   <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BYPASS: r_bypass <= i_cfg_data[0];
                REG_MODEL:  r_model  <= t_model'(i_cfg_data[1:0]);
                REG_DRIVE:  r_drive  <= i_cfg_data;
                REG_BIAS:   r_bias   <= i_cfg_data;
                default:    r_bypass <= r_bypass;
            endcase
        end
    end

    // Bias clamp and asymmetric coefficient, precomputed from configuration
    assign w_bias_c = (r_bias > Q15_ONE) ? Q15_ONE : r_bias;
    assign w_bias_p = 32'(w_bias_c) * 32'(C_0P65);

    always_ff @(posedge i_clk) begin
        r_coef <= C_0P35 + 16'((w_bias_p + 32'd16384) >> 15);
    end

    // Global advance: move when the output register is free or taken
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // Stage 1: magnitude times drive
    logic              r1_valid, r1_neg;
    logic [SW-1:0]     r1_raw;
    logic [PR_W-1:0]   r1_prod;
    logic [SW-2:0]     w_ax_lo;
    logic [SW-1:0]     w_ax;

    assign w_ax    = i_sample_in[SW-1] ? SW'(-i_sample_in) : SW'(i_sample_in);
    assign w_ax_lo = w_ax[SW-2:0];

    // Stage 2: round and saturate drive, clamp for clip model
    logic              r2_valid, r2_neg;
    logic [SW-1:0]     r2_raw;
    logic [MAG_W-1:0]  r2_m;
    logic [15:0]       r2_h;
    logic [PR_W-1:0]   w_m_full;
    logic [MAG_W-1:0]  w_m;

    // The only magnitude that needs SW bits is the most negative sample
    assign w_m_full = (r1_prod + PR_W'(512)) >> 10;
    assign w_m      = (w_m_full > PR_W'(XD_MAX)) ? XD_MAX : MAG_W'(w_m_full);

    // Stage 3: square and 1.3 scale
    logic              r3_valid, r3_neg;
    logic [SW-1:0]     r3_raw;
    logic [MAG_W-1:0]  r3_m;
    logic [37:0]       r3_sq;
    logic [31:0]       r3_hp;
    logic [37:0]       w_sq_r;

    assign w_sq_r = (r3_sq + 38'd16384) >> 15;

    // Stage 4: tanh arguments
    logic              r4_valid, r4_neg;
    logic [SW-1:0]     r4_raw;
    logic [MAG_W-1:0]  r4_m, r4_sq, r4_h13;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_raw  <= i_sample_in;
            r1_neg  <= i_sample_in[SW-1];
            r1_prod <= PR_W'({w_ax[SW-1], w_ax_lo}) * PR_W'(r_drive);

            r2_raw  <= r1_raw;
            r2_neg  <= r1_neg;
            r2_m    <= w_m;
            r2_h    <= (w_m > MAG_W'(Q15_ONE)) ? Q15_ONE : w_m[15:0];

            r3_raw  <= r2_raw;
            r3_neg  <= r2_neg;
            r3_m    <= r2_m;
            r3_sq   <= 38'(r2_m) * 38'(r2_m);
            r3_hp   <= 32'(r2_h) * 32'(C_1P3);

            r4_raw  <= r3_raw;
            r4_neg  <= r3_neg;
            r4_m    <= r3_m;
            r4_sq   <= (w_sq_r > 38'(XD_MAX)) ? XD_MAX : MAG_W'(w_sq_r);
            r4_h13  <= MAG_W'((r3_hp + 32'd16384) >> 15);
        end
    end

    // Stages 5-7: three table interpolators
    logic [15:0] w_t, w_a2, w_t1;

    twsc_tanh #(.TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)) u_tanh_x (
        .i_clk(i_clk), .i_en(w_en), .i_mag(r4_m), .o_tanh(w_t)
    );
    twsc_tanh #(.TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)) u_tanh_sq (
        .i_clk(i_clk), .i_en(w_en), .i_mag(r4_sq), .o_tanh(w_a2)
    );
    twsc_tanh #(.TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)) u_tanh_h (
        .i_clk(i_clk), .i_en(w_en), .i_mag(r4_h13), .o_tanh(w_t1)
    );

    // Hold sideband alongside the interpolators
    logic          r_sb_valid [0:2];
    logic          r_sb_neg   [0:2];
    logic [SW-1:0] r_sb_raw   [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb_valid[0] <= 1'b0;
            r_sb_valid[1] <= 1'b0;
            r_sb_valid[2] <= 1'b0;
        end else if (w_en) begin
            r_sb_valid[0] <= r4_valid;
            r_sb_valid[1] <= r_sb_valid[0];
            r_sb_valid[2] <= r_sb_valid[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb_neg[0] <= r4_neg;
            r_sb_neg[1] <= r_sb_neg[0];
            r_sb_neg[2] <= r_sb_neg[1];
            r_sb_raw[0] <= r4_raw;
            r_sb_raw[1] <= r_sb_raw[0];
            r_sb_raw[2] <= r_sb_raw[1];
        end
    end

    // Stage 8: model coefficient products
    logic          r8_valid, r8_neg;
    logic [SW-1:0] r8_raw;
    logic [31:0]   r8_tp, r8_ap;
    logic [31:0]   n8_tp, n8_ap;

    always_comb begin
        unique case (r_model)
            MODEL_SOFT: begin
                n8_tp = 32'(w_t);
                n8_ap = 32'(w_a2) * 32'(w_bias_c);
            end
            MODEL_CLIP: begin
                n8_tp = 32'(w_t1) * 32'(C_0P85);
                n8_ap = 32'(w_a2) * 32'(w_bias_c);
            end
            MODEL_ASYM: begin
                n8_tp = 32'(w_t) * 32'(C_0P75);
                n8_ap = 32'(w_a2) * 32'(r_coef);
            end
            MODEL_PLAIN: begin
                n8_tp = 32'(w_t);
                n8_ap = '0;
            end
            default: begin
                n8_tp = '0;
                n8_ap = '0;
            end
        endcase
    end

    // Stage 9: round, sum, saturate or bypass, output register
    logic                   r9_valid;
    logic signed [SW-1:0]   r9_out;
    logic [15:0]            w_tm, w_am;
    logic signed [YW-1:0]   w_y;
    logic signed [SW-1:0]   w_out;

    always_comb begin
        if (r_model == MODEL_SOFT || r_model == MODEL_PLAIN) begin
            w_tm = r8_tp[15:0];
        end else begin
            w_tm = 16'((r8_tp + 32'd16384) >> 15);
        end
        w_am = 16'((r8_ap + 32'd16384) >> 15);
        w_y  = (r8_neg ? -$signed(YW'(w_tm)) : $signed(YW'(w_tm))) + $signed(YW'(w_am));
        priority if (r_bypass) begin
            w_out = r8_raw;
        end else if (w_y > Y_HI) begin
            w_out = SW'(Y_HI);
        end else if (w_y < Y_LO) begin
            w_out = SW'(Y_LO);
        end else begin
            w_out = SW'(w_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
            r9_valid <= 1'b0;
        end else if (w_en) begin
            r8_valid <= r_sb_valid[2];
            r9_valid <= r8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_neg <= r_sb_neg[2];
            r8_raw <= r_sb_raw[2];
            r8_tp  <= n8_tp;
            r8_ap  <= n8_ap;
            r9_out <= w_out;
        end
    end

    assign o_valid      = r9_valid;
    assign o_sample_out = r9_out;

endmodule

// File: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import twsc_pkg::*;

    localparam int SW = SAMPLE_WIDTH_DEF;
    localparam int DEPTH = TANH_TABLE_DEPTH_DEF;
    localparam int PIPE_DEPTH = 9;
    localparam int STALL_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [SW-1:0] i_sample_in = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [SW-1:0] o_sample_out;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    tube_waveshaper_curve_core DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shaper settings as seen by the predictor
    logic shp_bypass;
    t_model shp_model;
    logic [15:0] shp_drive;
    logic [15:0] shp_bias;
    longint unsigned tanh_lut [DEPTH+1];

    logic signed [SW-1:0] pending_words[$];
    logic signed [SW-1:0] shaped_due[$];
    int errors = 0;
    int accepted_out = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;
    int rx_hold = 0;
    int long_hold_req = 0;

    // Build the tanh table: (1-E)/(1+E), E = exp(-16i/depth) in Q30
    function automatic longint unsigned tanh_point(int unsigned i);
        longint unsigned one, den, zq, term, s, e;
        longint acc;
        one = 64'd1 << 30;
        den = 64'(4 * DEPTH);
        zq = ((64'(i) << 30) + den / 2) / den;
        acc = longint'(one);
        term = one;
        for (int k = 1; k <= 10; k++) begin
            term = ((term * zq) >> 30) / 64'(k);
            if (k % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        s = longint'(acc);
        for (int k = 0; k < 6; k++) s = (s * s + (64'd1 << 29)) >> 30;
        e = (s > one) ? one : s;
        return (((one - e) << 15) + ((one + e) >> 1)) / (one + e);
    endfunction

    function automatic longint tanh_of_mag(longint unsigned mag);
        longint unsigned p, idx, frac, lo, hi;
        if (mag >= 262144) return longint'(tanh_lut[DEPTH]);
        p = mag * DEPTH;
        idx = p >> 18;
        frac = p & ((64'd1 << 18) - 1);
        if (idx >= DEPTH) return longint'(tanh_lut[DEPTH]);
        lo = tanh_lut[idx];
        hi = tanh_lut[idx + 1];
        if (hi < lo) hi = lo;
        return longint'(lo + (((hi - lo) * frac + (64'd1 << 17)) >> 18));
    endfunction

    function automatic longint tanh_odd(longint v);
        longint r;
        r = tanh_of_mag(v < 0 ? -v : v);
        return v < 0 ? -r : r;
    endfunction

    function automatic longint scale_q15(longint a, longint c);
        longint m;
        m = ((a < 0 ? -a : a) * c + 16384) >>> 15;
        return a < 0 ? -m : m;
    endfunction

    function automatic logic signed [SW-1:0] shape_word(logic signed [SW-1:0] x_in);
        longint x, mg, xd, sq, sq_t, th, bias, y, h, coef;
        if (shp_bypass) return x_in;
        x = x_in;
        mg = ((x < 0 ? -x : x) * longint'(shp_drive) + 512) >>> 10;
        if (mg > 262144) mg = 262144;
        xd = x < 0 ? -mg : mg;
        sq = (mg * mg + 16384) >>> 15;
        if (sq > 262144) sq = 262144;
        sq_t = tanh_of_mag(sq);
        bias = shp_bias > 32768 ? 32768 : shp_bias;
        th = tanh_odd(xd);
        case (shp_model)
            MODEL_SOFT: y = th + scale_q15(sq_t, bias);
            MODEL_CLIP: begin
                h = xd > 32768 ? 32768 : (xd < -32768 ? -32768 : xd);
                y = scale_q15(tanh_odd(scale_q15(h, C_1P3)), C_0P85)
                    + scale_q15(sq_t, bias);
            end
            MODEL_ASYM: begin
                coef = C_0P35 + scale_q15(bias, C_0P65);
                y = scale_q15(th, C_0P75) + scale_q15(sq_t, coef);
            end
            default: y = th;
        endcase
        if (y > (2 ** (SW - 1)) - 1) y = (2 ** (SW - 1)) - 1;
        if (y < -(2 ** (SW - 1))) y = -(2 ** (SW - 1));
        return y[SW-1:0];
    endfunction

    // Driver: offer queued words, idle in random bursts
    int tx_gap = 0;
    bit tx_pause = 1'b0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                shaped_due.push_back(shape_word(i_sample_in));
                void'(pending_words.pop_front());
            end
            if (i_valid && !o_ready) begin
                // hold the word
            end else if (tx_gap > 0 || tx_pause || pending_words.size() == 0
                         || (i_valid && o_ready && pending_words.size() == 0)) begin
                i_valid <= 1'b0;
                if (tx_gap > 0) tx_gap <= tx_gap - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_valid <= 1'b0;
                tx_gap <= $urandom_range(0, 9);
            end else begin
                i_valid <= 1'b1;
                i_sample_in <= pending_words[0];
            end
        end
    end

    // Monitor: check each output word, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                accepted_out++;
                if (shaped_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %0d", $time,
                             o_sample_out);
                    errors++;
                end else begin
                    if (o_sample_out !== shaped_due[0]) begin
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $time, shaped_due[0], o_sample_out);
                        errors++;
                    end
                    void'(shaped_due.pop_front());
                end
            end
            if (long_hold_req > 0) begin
                i_ready <= 1'b0;
                rx_hold <= long_hold_req;
                long_hold_req <= 0;
            end else if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold <= rx_hold - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                rx_hold <= $urandom_range(0, 9);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles with no accepted word
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_BYPASS: shp_bypass = data[0];
            REG_MODEL: shp_model = t_model'(data[1:0]);
            REG_DRIVE: shp_drive = data;
            default: shp_bias = data;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || shaped_due.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic set_shape(bit byp, t_model mdl, logic [15:0] drv, logic [15:0] bs);
        drain();
        write_reg(REG_BYPASS, {15'd0, byp});
        write_reg(REG_MODEL, {14'd0, mdl});
        write_reg(REG_DRIVE, drv);
        write_reg(REG_BIAS, bs);
    endtask

    function automatic logic signed [SW-1:0] rand_word();
        case ($urandom_range(0, 3))
            0: return SW'($urandom_range(0, 65535) - 32768);
            1: return SW'($urandom_range(0, 4095) - 2048);
            default: return SW'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] rand_drive();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 2048));
            1: return 16'($urandom_range(512, 8192));
            2: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        for (int i = 0; i <= DEPTH; i++) tanh_lut[i] = tanh_point(i);
        shp_bypass = 1'b0;
        shp_model = MODEL_SOFT;
        shp_drive = 16'd1024;
        shp_bias = 16'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes under reset settings, then every model
        pending_words = '{18'sh1FFFF, -18'sh20000, 18'sd0, 18'sd1, -18'sd1, 18'sd32768,
                          -18'sd32768, 18'sh15555, 18'sh2AAAA};
        for (int m = 0; m < 4; m++) begin
            set_shape(1'b0, t_model'(m), 16'hFFFF, 16'hFFFF);
            pending_words = '{18'sh1FFFF, -18'sh20000, 18'sd100};
            set_shape(1'b0, t_model'(m), 16'd0, 16'd32768);
            pending_words = '{18'sh1FFFF, -18'sd5};
        end
        set_shape(1'b1, MODEL_CLIP, 16'd4096, 16'd100);
        pending_words = '{18'sh1FFFF, -18'sh20000, 18'sh15555};

        // Random phases over settings
        for (int ph = 0; ph < 16; ph++) begin
            set_shape($urandom_range(0, 7) == 0, t_model'($urandom_range(0, 3)),
                      rand_drive(), $urandom_range(0, 3) == 0 ? 16'($urandom()) :
                      16'($urandom_range(0, 32768)));
            if (ph == 5) begin
                // long receiver hold while the sender keeps offering
                long_hold_req = 200;
            end
            if (ph == 15) calm = 1'b1;
            for (int n = 0; n < 100; n++) pending_words.push_back(rand_word());
            if (ph == 8) begin
                // sender pauses until every expected word has come
                wait (pending_words.size() == 0);
                tx_pause = 1'b1;
                while (shaped_due.size() > 0) @(posedge i_clk);
                tx_pause = 1'b0;
            end
        end
        drain();
        $display("tb: %0d words checked over bypass, all four curve models, drive and bias",
                 accepted_out);
        $display("tb: extremes, long output stall and full drain included");
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
